/* rtl/dma_region_translation_table_core_assert.svh */
`ifndef DMA_REGION_TRANSLATION_TABLE_CORE_ASSERT_SVH
`define DMA_REGION_TRANSLATION_TABLE_CORE_ASSERT_SVH

// same-cycle implication, inactive during reset
`define DRTT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, inactive during reset
`define DRTT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// next-cycle implication, also checked through reset
`define DRTT_ASSERT_RST(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/drtt_pkg.sv */
`default_nettype none
package drtt_pkg;

  localparam int DRTT_ENTRIES = 256;

  localparam int ADDR_W = 64;
  localparam int SIZE_W = 32;
  localparam int SLOT_W = 8;

  typedef enum logic [1:0] {
    CMD_INSERT    = 2'd0,
    CMD_FREE      = 2'd1,
    CMD_TRANSLATE = 2'd2,
    CMD_LOOKUP    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_FULL      = 2'd1,
    STAT_NOT_FOUND = 2'd2
  } stat_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic              valid;
    logic [ADDR_W-1:0] virt;
    logic [ADDR_W-1:0] phys;
    logic [SIZE_W-1:0] len;
  } entry_t;

  typedef struct packed {
    logic              hit;
    logic [SIZE_W-1:0] off;
  } cmp_res_t;

endpackage
`default_nettype wire

/* rtl/drtt_mem.sv */
`default_nettype none
module drtt_mem
  import drtt_pkg::*;
#(
  parameter int ENTRIES = DRTT_ENTRIES,
  localparam int IDXW = $clog2(ENTRIES)
) (
  input  wire logic            clk,
  input  wire logic            wr_en,
  input  wire logic [IDXW-1:0] wr_addr,
  input  wire entry_t          wr_data,
  input  wire logic            rd_en,
  input  wire logic [IDXW-1:0] rd_addr,
  output entry_t               rd_data
);

  entry_t mem [ENTRIES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

/* rtl/drtt_cmp.sv */
`default_nettype none
module drtt_cmp
  import drtt_pkg::*;
(
  input  wire entry_t            ent,
  input  wire logic [ADDR_W-1:0] addr,
  input  wire cmd_t              cmd,
  output cmp_res_t               res
);

  logic [ADDR_W:0]   diff;
  logic              borrow;
  logic              in_range;

  always_comb begin
    diff     = {1'b0, addr} - {1'b0, ent.virt};
    borrow   = diff[ADDR_W];
    in_range = !borrow && (diff[ADDR_W-1:SIZE_W] == '0) &&
               ((ent.len == '0) ? (diff[SIZE_W-1:0] == '0)
                                : (diff[SIZE_W-1:0] < ent.len));
    res.off  = diff[SIZE_W-1:0];
    if (cmd == CMD_INSERT) begin
      res.hit = !ent.valid;
    end else begin
      res.hit = ent.valid && in_range;
    end
  end

endmodule
`default_nettype wire

/* rtl/dma_region_translation_table_core.sv */
// channel | dir | tdata (low bit up)                              | tuser
// s_*     | in  | virt_addr[63:0] phys_base[127:64] size[159:128] | cmd
// m_*     | out | phys_addr[63:0] slot[71:64]                     | status
//
// Each transfer walks the slots, reading the table memory one entry per cycle
// through its single registered read port.
// After reset the table is swept entry by entry to clear the valid bits;
// s_tready stays low meanwhile.
// The result register holds a finished result while m_tready is low.
`default_nettype none
module dma_region_translation_table_core
  import drtt_pkg::*;
#(
  parameter int ENTRIES = DRTT_ENTRIES
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [159:0] s_tdata,  // virt_addr, phys_base, region_size
  input  wire logic [1:0]   s_tuser,  // cmd
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic [71:0]       m_tdata,  // phys_addr, slot
  output logic [1:0]        m_tuser   // status
);

  localparam int IDXW = $clog2(ENTRIES);
  localparam logic [IDXW-1:0] LAST = IDXW'(ENTRIES - 1);

  state_t            state, state_next;
  logic [IDXW-1:0]   rd_idx;
  logic              issue_done;
  logic              data_vld;
  logic [IDXW-1:0]   data_idx;
  cmd_t              cmd;
  logic [ADDR_W-1:0] virt;
  logic [ADDR_W-1:0] phys;
  logic [SIZE_W-1:0] size;
  logic              hit;
  logic [IDXW-1:0]   hit_idx;
  logic [SIZE_W-1:0] hit_off;
  logic [ADDR_W-1:0] hit_phys;

  logic              accept;
  logic              scan_end;
  logic              out_load;
  logic              rd_en;
  logic              wr_en;
  logic [IDXW-1:0]   wr_addr;
  entry_t            wr_data;
  entry_t            rd_data;
  cmp_res_t          res;
  logic [ADDR_W:0]   sum;
  logic [ADDR_W-1:0] paddr;
  stat_t             status;

  drtt_mem #(.ENTRIES(ENTRIES)) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_idx),
    .rd_data (rd_data)
  );

  drtt_cmp u_cmp (
    .ent  (rd_data),
    .addr (virt),
    .cmd  (cmd),
    .res  (res)
  );

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR:  if (rd_idx == LAST) state_next = ST_IDLE;
      ST_IDLE:   if (s_tvalid) state_next = ST_SCAN;
      ST_SCAN:   if (scan_end) state_next = ST_FINISH;
      ST_FINISH: if (!m_tvalid || m_tready) state_next = ST_IDLE;
      default:   state_next = ST_CLEAR;
    endcase
  end

  always_comb begin
    s_tready = (state == ST_IDLE);
    accept   = s_tready && s_tvalid;
    scan_end = (state == ST_SCAN) && data_vld && (res.hit || data_idx == LAST);
    out_load = (state == ST_FINISH) && (!m_tvalid || m_tready);
    rd_en    = (state == ST_SCAN) && !issue_done && !scan_end;

    wr_en   = (state == ST_CLEAR) ||
              (out_load && hit && (cmd inside {CMD_INSERT, CMD_FREE}));
    wr_addr = (state == ST_CLEAR) ? rd_idx : hit_idx;
    wr_data = '0;
    if (state == ST_FINISH && cmd == CMD_INSERT) begin
      wr_data = '{valid: 1'b1, virt: virt, phys: phys, len: size};
    end

    sum   = {1'b0, hit_phys} + {{(ADDR_W - SIZE_W + 1){1'b0}}, hit_off};
    paddr = '0;
    if (hit) begin
      case (cmd)
        CMD_TRANSLATE: paddr = sum[ADDR_W] ? '1 : sum[ADDR_W-1:0];
        CMD_LOOKUP:    paddr = hit_phys;
        default:       paddr = '0;
      endcase
    end
    if (hit) begin
      status = STAT_OK;
    end else if (cmd == CMD_INSERT) begin
      status = STAT_FULL;
    end else begin
      status = STAT_NOT_FOUND;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      rd_idx     <= '0;
      issue_done <= 1'b0;
      data_vld   <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      state    <= state_next;
      data_vld <= rd_en;
      if (state == ST_CLEAR) begin
        rd_idx <= (rd_idx == LAST) ? '0 : rd_idx + IDXW'(1);
      end else if (accept) begin
        rd_idx     <= '0;
        issue_done <= 1'b0;
      end else if (rd_en) begin
        if (rd_idx == LAST) begin
          issue_done <= 1'b1;
        end else begin
          rd_idx <= rd_idx + IDXW'(1);
        end
      end
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    data_idx <= rd_idx;
    if (accept) begin
      cmd  <= cmd_t'(s_tuser);
      virt <= s_tdata[63:0];
      phys <= s_tdata[127:64];
      size <= s_tdata[159:128];
    end
    if (scan_end) begin
      hit      <= res.hit;
      hit_idx  <= data_idx;
      hit_off  <= res.off;
      hit_phys <= rd_data.phys;
    end
    if (out_load) begin
      m_tdata <= {(hit ? SLOT_W'(hit_idx) : SLOT_W'(0)), paddr};
      m_tuser <= status;
    end
  end

endmodule
`default_nettype wire

/* rtl/drtt_checker.sv */
`default_nettype none
`include "dma_region_translation_table_core_assert.svh"
module drtt_checker
  import drtt_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [71:0] m_tdata,
  input wire logic [1:0]  m_tuser
);

  `DRTT_ASSERT_RST(a_reset_busy, rst, !s_tready, "ready during table clear")
  `DRTT_ASSERT_NEXT(a_one_at_a_time, s_tvalid && s_tready, !s_tready, "second transfer taken while busy")
  `DRTT_ASSERT_NOW(a_miss_zero, m_tvalid && m_tuser != STAT_OK, m_tdata == '0, "failed result carries data")
  `DRTT_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

endmodule

bind dma_region_translation_table_core drtt_checker u_drtt_checker (.*);
`default_nettype wire

/* dv/region_xlate_monitor.sv */
module region_xlate_monitor
  import drtt_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [159:0] s_tdata,  // virt_addr, phys_base, region_size
  input  logic [1:0]   s_tuser,  // cmd
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [71:0]  m_tdata,  // phys_addr, slot
  input  logic [1:0]   m_tuser,  // status
  output int           mismatches,
  output int           pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    stat_t       status;
    logic [63:0] phys_addr;
    logic [7:0]  slot;
  } xlate_result_t;

  logic        tbl_valid [DRTT_ENTRIES];
  logic [63:0] tbl_virt  [DRTT_ENTRIES];
  logic [63:0] tbl_phys  [DRTT_ENTRIES];
  logic [31:0] tbl_len   [DRTT_ENTRIES];

  xlate_result_t owed_results[$];

  function automatic int match_slot(logic [63:0] va);
    for (int i = 0; i < DRTT_ENTRIES; i++) begin
      if (tbl_valid[i]) begin
        if (tbl_len[i] == 32'd0) begin
          if (va == tbl_virt[i]) return i;
        end else if (va >= tbl_virt[i] && (va - tbl_virt[i]) < {32'd0, tbl_len[i]}) begin
          return i;
        end
      end
    end
    return -1;
  endfunction

  function automatic int free_slot();
    for (int i = 0; i < DRTT_ENTRIES; i++)
      if (!tbl_valid[i]) return i;
    return -1;
  endfunction

  function automatic xlate_result_t run_command(cmd_t c, logic [63:0] va, logic [63:0] pa,
                                                logic [31:0] sz);
    xlate_result_t r;
    int idx;
    logic [64:0] sum;
    r = '{status: STAT_OK, phys_addr: 64'd0, slot: 8'd0};
    if (c == CMD_INSERT) begin
      idx = free_slot();
      if (idx < 0) begin
        r.status = STAT_FULL;
      end else begin
        tbl_valid[idx] = 1'b1;
        tbl_virt[idx] = va;
        tbl_phys[idx] = pa;
        tbl_len[idx] = sz;
        r.slot = 8'(idx);
      end
    end else begin
      idx = match_slot(va);
      if (idx < 0) begin
        r.status = STAT_NOT_FOUND;
      end else begin
        r.slot = 8'(idx);
        case (c)
          CMD_FREE: begin
            tbl_valid[idx] = 1'b0;
          end
          CMD_TRANSLATE: begin
            // saturate on carry out of 64 bits
            sum = {1'b0, tbl_phys[idx]} + {1'b0, va - tbl_virt[idx]};
            r.phys_addr = sum[64] ? '1 : sum[63:0];
          end
          default: begin
            r.phys_addr = tbl_phys[idx];
          end
        endcase
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    xlate_result_t want;
    if (rst) begin
      foreach (tbl_valid[i]) tbl_valid[i] = 1'b0;
      owed_results.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        if (owed_results.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected transfer: expected none, actual status=%0d phys_addr=%h slot=%0d",
                   $time, m_tuser, m_tdata[63:0], m_tdata[71:64]);
        end else begin
          want = owed_results.pop_front();
          if (m_tuser !== want.status) begin
            mismatches++;
            $display("%0t: status mismatch: expected %0d, actual %0d",
                     $time, want.status, m_tuser);
          end
          if (m_tdata[63:0] !== want.phys_addr) begin
            mismatches++;
            $display("%0t: phys_addr mismatch: expected %h, actual %h",
                     $time, want.phys_addr, m_tdata[63:0]);
          end
          if (m_tdata[71:64] !== want.slot) begin
            mismatches++;
            $display("%0t: slot mismatch: expected %0d, actual %0d",
                     $time, want.slot, m_tdata[71:64]);
          end
        end
      end
      if (s_tvalid && s_tready)
        owed_results.push_back(run_command(cmd_t'(s_tuser), s_tdata[63:0], s_tdata[127:64],
                                           s_tdata[159:128]));
    end
    pending = owed_results.size();
  end

endmodule

/* dv/testbench.sv */
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import drtt_pkg::*;

  typedef struct {
    logic [63:0] base;
    logic [31:0] len;
  } span_t;

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [159:0] s_tdata;  // virt_addr, phys_base, region_size
  logic [1:0]   s_tuser;  // cmd
  logic         m_tvalid;
  logic         m_tready;
  logic [71:0]  m_tdata;  // phys_addr, slot
  logic [1:0]   m_tuser;  // status

  int    fail_count;
  int    results_owed;
  bit    quiet;
  span_t known_spans[$];

  dma_region_translation_table_core u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  region_xlate_monitor u_monitor (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .mismatches (fail_count),
    .pending    (results_owed)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  function automatic int draw_gap();
    return quiet ? 0 : $urandom_range(0, 11);
  endfunction

  function automatic logic [63:0] wide_rand();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [31:0] rand_size();
    case ($urandom_range(0, 9))
      0: return 32'd0;
      1: return $urandom;
      2: return 32'hFFFF_FFFF;
      default: return $urandom_range(1, 4096);
    endcase
  endfunction

  function automatic logic [63:0] rand_base();
    case ($urandom_range(0, 7))
      0: return 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 4095));
      1: return 64'($urandom_range(0, 4095));
      default: return wide_rand();
    endcase
  endfunction

  // pick >= 0 marks an address inside the recorded span at that index
  function automatic logic [63:0] probe_addr(output int pick);
    span_t s;
    int k;
    pick = -1;
    if (known_spans.size() == 0) return wide_rand();
    k = $urandom_range(0, known_spans.size() - 1);
    s = known_spans[k];
    case ($urandom_range(0, 9))
      7: return s.base + 64'(s.len);
      8: return s.base - 64'd1;
      9: return wide_rand();
      default: begin
        pick = k;
        return s.base + ((s.len == 32'd0) ? 64'd0 : 64'($urandom_range(0, s.len - 1)));
      end
    endcase
  endfunction

  task automatic send_request(cmd_t c, logic [63:0] va, logic [63:0] pa, logic [31:0] sz);
    int gap;
    gap = draw_gap();
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {sz, pa, va};
    s_tuser <= c;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (c == CMD_INSERT) begin
      known_spans.push_back('{base: va, len: sz});
      if (known_spans.size() > 320) void'(known_spans.pop_front());
    end
  endtask

  task automatic random_request(int ins_pct, int free_pct);
    int p;
    int pick;
    logic [63:0] va;
    p = $urandom_range(0, 99);
    if (p < ins_pct) begin
      send_request(CMD_INSERT, rand_base(), rand_base(), rand_size());
    end else begin
      va = probe_addr(pick);
      if (p < ins_pct + free_pct) begin
        if (pick >= 0) known_spans.delete(pick);
        send_request(CMD_FREE, va, wide_rand(), $urandom);
      end else begin
        send_request(p[0] ? CMD_TRANSLATE : CMD_LOOKUP, va, wide_rand(), $urandom);
      end
    end
  endtask

  initial begin
    m_tready = 1'b0;
    wait (!rst);
    forever begin
      int stall;
      stall = draw_gap();
      @(negedge clk);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
    end
  end

  initial begin
    #18ms;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = CMD_INSERT;
    quiet = 1'b0;
    rst = 1'b1;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_request(CMD_TRANSLATE, 64'd0, wide_rand(), $urandom);
    send_request(CMD_LOOKUP, '1, wide_rand(), $urandom);
    send_request(CMD_FREE, 64'd0, wide_rand(), $urandom);
    send_request(CMD_INSERT, 64'd0, '1, 32'hFFFF_FFFF);
    send_request(CMD_TRANSLATE, 64'hFFFF_FFFE, wide_rand(), $urandom);
    send_request(CMD_TRANSLATE, 64'd0, wide_rand(), $urandom);
    send_request(CMD_INSERT, 64'hFFFF_FFFF_FFFF_FFF0, 64'h1000, 32'hFFFF_FFFF);
    send_request(CMD_TRANSLATE, '1, wide_rand(), $urandom);
    send_request(CMD_LOOKUP, 64'h1_0000_0000, wide_rand(), $urandom);
    send_request(CMD_INSERT, 64'h8000_0000_0000_0000, 64'h1234, 32'd0);
    send_request(CMD_TRANSLATE, 64'h8000_0000_0000_0000, wide_rand(), $urandom);
    send_request(CMD_TRANSLATE, 64'h8000_0000_0000_0001, wide_rand(), $urandom);
    send_request(CMD_INSERT, 64'h10, 64'hABCD, 32'h100);
    send_request(CMD_TRANSLATE, 64'h20, wide_rand(), $urandom);
    send_request(CMD_FREE, 64'h20, wide_rand(), $urandom);
    send_request(CMD_TRANSLATE, 64'h20, wide_rand(), $urandom);
    send_request(CMD_INSERT, 64'h5000, 64'd0, 32'd1);
    send_request(CMD_LOOKUP, 64'h5000, wide_rand(), $urandom);
    send_request(CMD_LOOKUP, 64'h5001, wide_rand(), $urandom);
    send_request(CMD_FREE, 64'h8000_0000_0000_0000, wide_rand(), $urandom);
    send_request(CMD_FREE, 64'h8000_0000_0000_0000, wide_rand(), $urandom);

    // fill the table, then churn near full
    for (int n = 0; n < 290; n++) begin
      if (n % 40 == 0) quiet = ($urandom_range(0, 3) == 0);
      random_request(80, 5);
    end
    for (int n = 0; n < 260; n++) begin
      if (n % 40 == 0) quiet = ($urandom_range(0, 3) == 0);
      random_request(35, 25);
    end
    @(negedge clk);
    s_tvalid <= 1'b0;

    wait (results_owed == 0);
    repeat (DRTT_ENTRIES + 16) @(posedge clk);
    if (fail_count == 0 && results_owed == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl
rtl/drtt_pkg.sv
rtl/drtt_mem.sv
rtl/drtt_cmp.sv
rtl/dma_region_translation_table_core.sv
rtl/drtt_checker.sv
dv/region_xlate_monitor.sv
dv/testbench.sv
